// ===== rtl/integer_to_radix_ascii_defines.svh =====
// Assertion macros shared by the integer-to-radix-ASCII checker.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRA_ASSERT_SAME(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("ira check failed");

// Next-cycle implication, disabled during reset.
`define IRA_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("ira check failed");

`endif

// ===== rtl/ira_pkg.sv =====
// Shared types, constants and helper functions of the integer-to-radix-ASCII block.
`timescale 1ns / 1ps

package ira_pkg;

	// Datapath sizing
	localparam int VALUE_BITS  = 64;
	localparam int VALUE_W     = 64;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int STORE_DEPTH = VALUE_BITS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(VALUE_BITS + 1);

	// Character and base constants
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 8'h61;

	// Input and result beats
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
	} ira_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} ira_out_t;

	// Divider command and status
	typedef struct packed {
		logic load;
		logic next;
	} ira_div_cmd_t;

	typedef struct packed {
		logic               done;
		logic               quot_zero;
		logic [RADIX_W-1:0] remainder;
	} ira_div_stat_t;

	// Digit store write port
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [RADIX_W-1:0] data;
	} ira_wr_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} ira_state_t;

	// Saturate the base into 2..36
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// Digit to ASCII: 0..9 -> '0'..'9', 10..35 -> 'a'..'z'
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		logic [CHAR_W-1:0] res;
		dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < DECIMAL_LIMIT) begin
			res = dx + CHAR_ZERO;
		end else begin
			res = dx - {{(CHAR_W-RADIX_W){1'b0}}, DECIMAL_LIMIT} + CHAR_LOWER_A;
		end
		return res;
	endfunction

endpackage

// ===== rtl/ira_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
`timescale 1ns / 1ps

module ira_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ira_pkg::ira_div_cmd_t           cmd,
	input  logic [ira_pkg::VALUE_BITS-1:0]  load_value,
	input  logic [ira_pkg::RADIX_W-1:0]     load_base,
	output ira_pkg::ira_div_stat_t          stat
);

	logic [ira_pkg::VALUE_BITS-1:0] quo_q;
	logic [ira_pkg::RADIX_W-1:0]    rem_q;
	logic [ira_pkg::RADIX_W-1:0]    base_q;
	logic [ira_pkg::CNT_W-1:0]      bit_cnt_q;
	logic                           run_q;
	logic                           done_q;

	logic [ira_pkg::RADIX_W:0]      trial;
	logic [ira_pkg::RADIX_W:0]      diff;
	logic                           ge;
	logic [ira_pkg::RADIX_W-1:0]    rem_n;

	// Trial subtract of the base from the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[ira_pkg::VALUE_BITS-1]};
		diff  = trial - {1'b0, base_q};
		ge    = (trial >= {1'b0, base_q});
		rem_n = ge ? diff[ira_pkg::RADIX_W-1:0] : trial[ira_pkg::RADIX_W-1:0];
	end

	// Pass control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load || cmd.next) begin
				run_q     <= 1'b1;
				bit_cnt_q <= ira_pkg::CNT_W'(ira_pkg::VALUE_BITS);
			end else if (run_q) begin
				bit_cnt_q <= bit_cnt_q - ira_pkg::CNT_W'(1);
				if (bit_cnt_q == ira_pkg::CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend/quotient shift register and remainder
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q  <= load_value;
			base_q <= load_base;
			rem_q  <= '0;
		end else if (cmd.next) begin
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[ira_pkg::VALUE_BITS-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign stat.done      = done_q;
	assign stat.quot_zero = ~|quo_q;
	assign stat.remainder = rem_q;

endmodule

// ===== rtl/ira_digit_store.sv =====
// Digit store: one write port, one registered read port.
`timescale 1ns / 1ps

module ira_digit_store (
	input  logic                         clk,
	input  ira_pkg::ira_wr_t             wr,
	input  logic [ira_pkg::ADDR_W-1:0]   rd_addr,
	output logic [ira_pkg::RADIX_W-1:0]  rd_data
);

	logic [ira_pkg::RADIX_W-1:0] mem_q [ira_pkg::STORE_DEPTH];
	logic [ira_pkg::RADIX_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// Top level: unsigned integer to ASCII digits in a base from 2 to 36.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive item (value, radix) and raise start; the beat is taken
//   at a clock edge where start is high and busy is low. busy stays high until
//   the last character of that item has been emitted.
//   Result channel: one beat per digit, most significant first, each shown for
//   exactly one cycle with strobe high; result.last marks the final digit. The
//   receiver cannot stall, so every strobed beat must be captured.
//   Radix below 2 is treated as 2, above 36 as 36. A zero value gives one '0'.
// Digit sequence:
//   Each digit takes one pass of the bit-serial divider over VALUE_BITS
//   quotient bits; the done pulse that ends a pass also starts the next pass.
//   Emission reads each character from the digit store in ST_EMIT_RD and
//   shows it in ST_EMIT_OUT. A 64-bit decimal value has up to 20 digits.
// Reset:
//   arst_n low returns the sequencer to idle and clears the digit count; the
//   digit store is not cleared, as every entry is written before it is read.

module integer_to_radix_ascii (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ira_pkg::ira_in_t item,
	output logic             strobe,
	output ira_pkg::ira_out_t result
);

	ira_pkg::ira_state_t     state_q;
	ira_pkg::ira_state_t     state_n;
	logic [ira_pkg::CNT_W-1:0] digit_count_q;
	logic [ira_pkg::CNT_W-1:0] idx_q;
	logic [ira_pkg::CNT_W-1:0] idx_m1;

	ira_pkg::ira_div_cmd_t   div_cmd;
	ira_pkg::ira_div_stat_t  div_stat;
	ira_pkg::ira_wr_t        wr;
	logic [ira_pkg::ADDR_W-1:0]  rd_addr;
	logic [ira_pkg::RADIX_W-1:0] rd_data;

	ira_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (div_cmd),
		.load_value (item.value[ira_pkg::VALUE_BITS-1:0]),
		.load_base  (ira_pkg::clamp_radix(item.radix)),
		.stat       (div_stat)
	);

	ira_digit_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign idx_m1 = idx_q - ira_pkg::CNT_W'(1);

	// State register and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ira_pkg::ST_IDLE;
			digit_count_q <= '0;
			idx_q         <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				ira_pkg::ST_IDLE: begin
					if (start) begin
						digit_count_q <= '0;
					end
				end
				ira_pkg::ST_DIV: begin
					if (div_stat.done) begin
						digit_count_q <= digit_count_q + ira_pkg::CNT_W'(1);
						idx_q         <= digit_count_q + ira_pkg::CNT_W'(1);
					end
				end
				ira_pkg::ST_EMIT_RD: begin
					idx_q <= idx_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// Next state and outputs
	always_comb begin
		state_n            = state_q;
		busy               = 1'b1;
		strobe             = 1'b0;
		div_cmd            = '0;
		wr                 = '0;
		rd_addr            = idx_m1[ira_pkg::ADDR_W-1:0];
		result.digit_char  = ira_pkg::to_ascii(rd_data);
		result.last        = (idx_q == '0);
		case (state_q)
			ira_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					div_cmd.load = 1'b1;
					state_n      = ira_pkg::ST_DIV;
				end
			end
			ira_pkg::ST_DIV: begin
				// store each remainder, least significant digit first
				if (div_stat.done) begin
					wr.en   = 1'b1;
					wr.addr = digit_count_q[ira_pkg::ADDR_W-1:0];
					wr.data = div_stat.remainder;
					if (div_stat.quot_zero) begin
						state_n = ira_pkg::ST_EMIT_RD;
					end else begin
						div_cmd.next = 1'b1;
					end
				end
			end
			ira_pkg::ST_EMIT_RD: begin
				state_n = ira_pkg::ST_EMIT_OUT;
			end
			ira_pkg::ST_EMIT_OUT: begin
				strobe = 1'b1;
				if (idx_q == '0) begin
					state_n = ira_pkg::ST_IDLE;
				end else begin
					state_n = ira_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_n = ira_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ira_checker.sv =====
// Port-level checker for the integer-to-radix-ASCII block, with its bind.
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_defines.svh"

module ira_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ira_pkg::ira_in_t  item,
	input logic              strobe,
	input ira_pkg::ira_out_t result
);

	logic accept;
	logic char_ok;

	assign accept  = start && !busy;
	assign char_ok = ((result.digit_char >= 8'h30) && (result.digit_char <= 8'h39)) ||
		((result.digit_char >= 8'h61) && (result.digit_char <= 8'h7a));

	// A result beat only comes while an item is in progress
	`IRA_ASSERT_SAME(a_strobe_busy, clk, arst_n, strobe, busy)
	// An accepted item keeps the block busy on the next cycle
	`IRA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	// No result beat follows directly on another
	`IRA_ASSERT_NEXT(a_strobe_gap, clk, arst_n, strobe, !strobe)
	// The final digit releases the block
	`IRA_ASSERT_NEXT(a_last_idle, clk, arst_n, strobe && result.last, !busy)
	// Every emitted character is a digit or a lowercase letter
	`IRA_ASSERT_SAME(a_char_range, clk, arst_n, strobe, char_ok)

endmodule

bind integer_to_radix_ascii ira_checker u_ira_checker (.*);
